// ===== hw/rtl/qte_pkg.sv =====
// shared types, constants and tables for the quaternion to euler converter
`default_nettype none
package qte_pkg;

  // datapath width of the cordic vectors and argument words
  localparam int DW = 36;
  // width of the q24 radian angle accumulator
  localparam int AW = 28;
  // width used for angle scaling before clamping
  localparam int ZW = 30;
  // entries in the arctangent table
  localparam int TABLE_LEN = 24;
  // steps of the square root chain
  localparam int SQRT_STEPS = 32;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic signed [DW-1:0] ONE_Q28 = DW'(268435456);
  localparam logic signed [AW-1:0] HALF_PI_Q24 = AW'(26353589);
  localparam logic signed [ZW-1:0] PI_Q12 = ZW'(12868);
  localparam logic signed [ZW-1:0] TWO_PI_Q12 = ZW'(25736);

  typedef enum logic [1:0] {
    PC_NORMAL = 2'd0,
    PC_NORTH  = 2'd1,
    PC_SOUTH  = 2'd2
  } pole_t;

  // one vector travelling through the cordic chain
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } cordic_t;

  // arguments that ride along the square root chain
  typedef struct packed {
    logic signed [DW-1:0] yaw_y;
    logic signed [DW-1:0] yaw_x;
    logic signed [DW-1:0] roll_y;
    logic signed [DW-1:0] roll_x;
    logic signed [DW-1:0] s;
    pole_t                pc;
  } side_t;

  // atan(2^-i) in q24 radians, rounded to nearest
  function automatic logic signed [AW-1:0] atan_q24(input int idx);
    logic signed [AW-1:0] r;
    unique case (idx)
      0:  r = AW'(13176795);
      1:  r = AW'(7778716);
      2:  r = AW'(4110060);
      3:  r = AW'(2086331);
      4:  r = AW'(1047214);
      5:  r = AW'(524117);
      6:  r = AW'(262123);
      7:  r = AW'(131069);
      8:  r = AW'(65536);
      9:  r = AW'(32768);
      10: r = AW'(16384);
      11: r = AW'(8192);
      12: r = AW'(4096);
      13: r = AW'(2048);
      14: r = AW'(1024);
      15: r = AW'(512);
      16: r = AW'(256);
      17: r = AW'(128);
      18: r = AW'(64);
      19: r = AW'(32);
      20: r = AW'(16);
      21: r = AW'(8);
      22: r = AW'(4);
      23: r = AW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // q24 angle to q12 with floor, clamped to +-lim
  function automatic logic signed [16:0] to_q12(input logic signed [ZW-1:0] a,
                                                input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    r = a >>> 12;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[16:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qte_isqrt_cell.sv =====
// one step of the pipelined integer square root
`default_nettype none
module qte_isqrt_cell import qte_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        vld_i,
  input  wire logic [63:0] rem_i,
  input  wire logic [63:0] res_i,
  input  wire side_t       side_i,
  output logic             vld_o,
  output logic [63:0]      rem_o,
  output logic [63:0]      res_o,
  output side_t            side_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic        vld_r;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  side_t       side_r;
  logic [63:0] trial;

  always_comb begin
    trial = res_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt = rem_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      rem_nxt = rem_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      res_r  <= res_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign res_o  = res_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qte_cordic_cell.sv =====
// one micro-rotation of the cordic vectoring chain
`default_nettype none
module qte_cordic_cell import qte_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    vld_i,
  input  wire cordic_t d_i,
  input  wire pole_t   pc_i,
  output logic         vld_o,
  output cordic_t      d_o,
  output pole_t        pc_o
);

  localparam logic signed [AW-1:0] ANG = atan_q24(IDX);

  logic    vld_r;
  cordic_t d_r, d_nxt;
  pole_t   pc_r;
  logic signed [DW-1:0] xs, ys;

  always_comb begin
    xs = d_i.x >>> IDX;
    ys = d_i.y >>> IDX;
    d_nxt = d_i;
    if (d_i.y >= 0) begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + ANG;
    end else begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= d_nxt;
      pc_r <= pc_i;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;
  assign pc_o  = pc_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qte_cordic_lane.sv =====
// quadrant fold followed by a row of cordic cells, one atan2 per item
`default_nettype none
module qte_cordic_lane import qte_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_i,
  input  wire logic signed [DW-1:0] y_i,
  input  wire logic signed [DW-1:0] x_i,
  input  wire pole_t                pc_i,
  output logic                      vld_o,
  output logic signed [AW-1:0]      z_o,
  output logic                      zero_o,
  output pole_t                     pc_o
);

  logic    vld_c [0:STAGES];
  cordic_t d_c   [0:STAGES];
  pole_t   pc_c  [0:STAGES];

  logic    pre_vld_r;
  cordic_t pre_r, pre_nxt;
  pole_t   pre_pc_r;

  // fold the left half plane onto the right one
  always_comb begin
    pre_nxt.x    = x_i;
    pre_nxt.y    = y_i;
    pre_nxt.z    = '0;
    pre_nxt.zero = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        pre_nxt.x = y_i;
        pre_nxt.y = -x_i;
        pre_nxt.z = HALF_PI_Q24;
      end else begin
        pre_nxt.x = -y_i;
        pre_nxt.y = x_i;
        pre_nxt.z = -HALF_PI_Q24;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r    <= pre_nxt;
      pre_pc_r <= pc_i;
    end
  end

  assign vld_c[0] = pre_vld_r;
  assign d_c[0]   = pre_r;
  assign pc_c[0]  = pre_pc_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    qte_cordic_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_c[i]),
      .d_i   (d_c[i]),
      .pc_i  (pc_c[i]),
      .vld_o (vld_c[i+1]),
      .d_o   (d_c[i+1]),
      .pc_o  (pc_c[i+1])
    );
  end

  assign vld_o  = vld_c[STAGES];
  assign z_o    = d_c[STAGES].z;
  assign zero_o = d_c[STAGES].zero;
  assign pc_o   = pc_c[STAGES];

endmodule
`default_nettype wire

// ===== hw/rtl/quaternion_to_euler_core.sv =====
// top level: quaternion to yaw, pitch and roll with pole detection
//
//   channel | signals                                         | role
//   in      | in_valid in_ready in_quat_w/x/y/z               | one quaternion, q2.14
//   out     | out_valid out_ready out_yaw/pitch/roll_angle,   | angles in rad*4096
//           | out_pole_case                                   | and pole code
//
// one item enters per cycle while in_ready is high; the stages in order are
// products, sums, split multiply, recombine, 32-step root chain, fold, cordic row, output
// the 32-cell square root chain and the cordic row set the latency, not the rate
// synchronous active-low reset empties the pipeline and the output buffer
// a stall on out holds the whole chain once the two-entry output buffer is full
`default_nettype none
module quaternion_to_euler_core import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_yaw_angle,
  output logic signed [14:0]      out_pitch_angle,
  output logic signed [14:0]      out_roll_angle,
  output logic [1:0]              out_pole_case
);

  // pipeline advances while the skid slot is free
  logic en;

  // stage 1: all products
  logic v1_r;
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, wx_r, yz_r, wz_r, xy_r, wy_r, xz_r;
  logic signed [15:0] w1_r, y1_r;

  // stage 2: norm, s, pole decision, atan2 arguments
  logic v2_r;
  side_t side2_r, side2_nxt;
  logic [32:0] a2_r, a2_nxt, b2_r, b2_nxt;
  logic signed [DW-1:0] n2, two_s2, amb2, apb2;

  // stage 3: partial products of a*b
  logic v3_r;
  side_t side3_r;
  logic [33:0] ll3_r;
  logic [32:0] lh3_r, hl3_r;
  logic [31:0] hh3_r;

  // stage 4: full product for the root
  logic v4_r;
  side_t side4_r;
  logic [63:0] v64_r;

  // square root chain
  logic  sq_vld  [0:SQRT_STEPS];
  logic [63:0] sq_rem [0:SQRT_STEPS];
  logic [63:0] sq_res [0:SQRT_STEPS];
  side_t sq_side [0:SQRT_STEPS];

  // cordic lanes
  logic signed [DW-1:0] root_x;
  logic cy_vld, cp_vld, cr_vld;
  logic signed [AW-1:0] yaw_z, pitch_z, roll_z;
  logic yaw_zero, pitch_zero, roll_zero;
  pole_t pc_y, pc_p, pc_r;
  side_t sq_last;

  // result formatting
  logic signed [ZW-1:0] yaw_a, pitch_a, roll_a, yaw_pole;
  logic signed [16:0] yaw_q, pitch_q, roll_q;
  logic signed [15:0] res_yaw;
  logic signed [14:0] res_pitch, res_roll;
  logic inc_vld;

  // output register and skid slot
  logic out_valid_r, skid_valid_r;
  logic signed [15:0] out_yaw_r, skid_yaw_r;
  logic signed [14:0] out_pitch_r, skid_pitch_r, out_roll_r, skid_roll_r;
  pole_t out_pc_r, skid_pc_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 1 products, one multiplier each
  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= in_quat_w * in_quat_w;
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
      wx_r <= in_quat_w * in_quat_x;
      yz_r <= in_quat_y * in_quat_z;
      wz_r <= in_quat_w * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;
      wy_r <= in_quat_w * in_quat_y;
      xz_r <= in_quat_x * in_quat_z;
      w1_r <= in_quat_w;
      y1_r <= in_quat_y;
    end
  end

  // stage 2 sums and pole test
  always_comb begin
    n2     = DW'(ww_r) + DW'(xx_r) + DW'(yy_r) + DW'(zz_r);
    two_s2 = (DW'(wx_r) + DW'(yz_r)) <<< 1;
    amb2   = (n2 - two_s2) >>> 1;
    apb2   = (n2 + two_s2) >>> 1;
    a2_nxt = amb2[32:0];
    b2_nxt = apb2[32:0];
    side2_nxt.s      = DW'(wx_r) + DW'(yz_r);
    side2_nxt.roll_y = (DW'(wy_r) - DW'(xz_r)) <<< 1;
    side2_nxt.roll_x = ONE_Q28 - ((DW'(yy_r) + DW'(xx_r)) <<< 1);
    if (two_s2 > n2) begin
      side2_nxt.pc = PC_NORTH;
    end else if (two_s2 < -n2) begin
      side2_nxt.pc = PC_SOUTH;
    end else begin
      side2_nxt.pc = PC_NORMAL;
    end
    // at a pole the yaw lane takes atan2(y, w) instead
    if (side2_nxt.pc == PC_NORMAL) begin
      side2_nxt.yaw_y = (DW'(wz_r) - DW'(xy_r)) <<< 1;
      side2_nxt.yaw_x = ONE_Q28 - ((DW'(zz_r) + DW'(xx_r)) <<< 1);
    end else begin
      side2_nxt.yaw_y = DW'(y1_r);
      side2_nxt.yaw_x = DW'(w1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side2_nxt;
      a2_r    <= a2_nxt;
      b2_r    <= b2_nxt;
    end
  end

  // stage 3: a*b split into a 17-bit low half and a 16-bit high half
  always_ff @(posedge clk) begin
    if (en) begin
      ll3_r   <= 34'(a2_r[16:0]) * 34'(b2_r[16:0]);
      lh3_r   <= 33'(a2_r[16:0]) * 33'(b2_r[32:17]);
      hl3_r   <= 33'(a2_r[32:17]) * 33'(b2_r[16:0]);
      hh3_r   <= 32'(a2_r[32:17]) * 32'(b2_r[32:17]);
      side3_r <= side2_r;
    end
  end

  // stage 4: recombine
  always_ff @(posedge clk) begin
    if (en) begin
      v64_r   <= (64'(hh3_r) << 34) + ((64'(lh3_r) + 64'(hl3_r)) << 17) + 64'(ll3_r);
      side4_r <= side3_r;
    end
  end

  assign sq_vld[0]  = v4_r;
  assign sq_rem[0]  = v64_r;
  assign sq_res[0]  = '0;
  assign sq_side[0] = side4_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qte_isqrt_cell #(.STEP(k)) u_sqrt (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_vld[k]),
      .rem_i  (sq_rem[k]),
      .res_i  (sq_res[k]),
      .side_i (sq_side[k]),
      .vld_o  (sq_vld[k+1]),
      .rem_o  (sq_rem[k+1]),
      .res_o  (sq_res[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  assign sq_last = sq_side[SQRT_STEPS];
  assign root_x  = $signed(DW'({1'b0, sq_res[SQRT_STEPS][31:0]}));

  qte_cordic_lane #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(sq_vld[SQRT_STEPS]),
    .y_i(sq_last.yaw_y), .x_i(sq_last.yaw_x), .pc_i(sq_last.pc),
    .vld_o(cy_vld), .z_o(yaw_z), .zero_o(yaw_zero), .pc_o(pc_y)
  );

  qte_cordic_lane #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(sq_vld[SQRT_STEPS]),
    .y_i(sq_last.s), .x_i(root_x), .pc_i(sq_last.pc),
    .vld_o(cp_vld), .z_o(pitch_z), .zero_o(pitch_zero), .pc_o(pc_p)
  );

  qte_cordic_lane #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(sq_vld[SQRT_STEPS]),
    .y_i(sq_last.roll_y), .x_i(sq_last.roll_x), .pc_i(sq_last.pc),
    .vld_o(cr_vld), .z_o(roll_z), .zero_o(roll_zero), .pc_o(pc_r)
  );

  // angle scaling, clamping and pole answers
  always_comb begin
    yaw_a    = yaw_zero   ? '0 : ZW'(yaw_z);
    pitch_a  = pitch_zero ? '0 : ZW'(pitch_z);
    roll_a   = roll_zero  ? '0 : ZW'(roll_z);
    yaw_pole = yaw_a <<< 1;
    pitch_q  = to_q12(pitch_a, PI_Q12);
    roll_q   = to_q12(roll_a, PI_Q12);
    unique case (pc_p)
      PC_NORTH: begin
        yaw_q     = to_q12(yaw_pole, TWO_PI_Q12);
        res_pitch = PI_Q12[14:0];
        res_roll  = '0;
      end
      PC_SOUTH: begin
        yaw_q     = to_q12(-yaw_pole, TWO_PI_Q12);
        res_pitch = -(PI_Q12[14:0]);
        res_roll  = '0;
      end
      default: begin
        yaw_q     = to_q12(yaw_a, PI_Q12);
        res_pitch = pitch_q[14:0];
        res_roll  = roll_q[14:0];
      end
    endcase
    res_yaw = yaw_q[15:0];
    // all lanes run in lock step, the pitch lane's valid stands for all
    inc_vld = cp_vld && en;
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= inc_vld;
      end
    end else if (inc_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_yaw_r   <= skid_yaw_r;
        out_pitch_r <= skid_pitch_r;
        out_roll_r  <= skid_roll_r;
        out_pc_r    <= skid_pc_r;
      end else begin
        out_yaw_r   <= res_yaw;
        out_pitch_r <= res_pitch;
        out_roll_r  <= res_roll;
        out_pc_r    <= pc_p;
      end
    end else if (inc_vld) begin
      skid_yaw_r   <= res_yaw;
      skid_pitch_r <= res_pitch;
      skid_roll_r  <= res_roll;
      skid_pc_r    <= pc_p;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_yaw_angle   = out_yaw_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pole_case   = out_pc_r;

`ifndef NO_ASSERTIONS
  // skid slot only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full with empty output register");

  // lanes stay in lock step, pole codes compared only for live items
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (cy_vld == cp_vld) && (cr_vld == cp_vld) &&
    (!cp_vld || ((pc_y == pc_p) && (pc_r == pc_p))))
    else $error("cordic lanes out of step");

  // pole answers have zero roll and full pitch
  a_pole_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_pc_r != PC_NORMAL) |->
      (out_roll_r == '0) && ((out_pitch_r == PI_Q12[14:0]) ||
                             (out_pitch_r == -(PI_Q12[14:0]))))
    else $error("pole result with wrong pitch or roll");
`endif

endmodule
`default_nettype wire
